FILE: rtl/core/gtg_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal package
// Shared widths, constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int FRACTION_BITS = 8;

	localparam int POS_W   = 14;
	localparam int HEAD_W  = 15;
	localparam int GAIN_W  = 12;
	localparam int SPEED_W = 16;
	localparam int GATE_W  = 16;
	localparam int AGATE_W = 15;
	localparam int ANG_W   = 15;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;

	localparam int DIFF_W    = POS_W + 1;
	localparam int PRE_SHIFT = 14;
	localparam int VEC_W     = 32;
	localparam int Z_W       = 20;
	localparam int ZR_W      = Z_W - 4;
	localparam int ANGLE_W   = 17;
	localparam int INV_W     = 16;
	localparam int PROD_W    = VEC_W - 1 + INV_W;
	localparam int DIST_SHIFT = 38 - FRACTION_BITS;
	localparam int DIST_W    = 7 + FRACTION_BITS;
	localparam int CMP_W     = (DIST_W > GATE_W) ? DIST_W : GATE_W;
	localparam int LPROD_W   = GAIN_W + DIST_W;
	localparam int LIN_W     = LPROD_W - FRACTION_BITS;

	localparam logic signed [Z_W-1:0] PI_Q16     = Z_W'(205887);
	localparam logic signed [Z_W-1:0] ANGLE_RND  = Z_W'(8);
	localparam logic [INV_W-1:0]      INV_GAIN   = INV_W'(39797);
	localparam logic [PROD_W-1:0]     DIST_RND   = PROD_W'(1) << (DIST_SHIFT - 1);

	localparam logic [POS_W-1:0]   RST_GOAL_X     = POS_W'(768);
	localparam logic [POS_W-1:0]   RST_GOAL_Y     = POS_W'(1024);
	localparam logic [GAIN_W-1:0]  RST_GAIN       = GAIN_W'(256);
	localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = SPEED_W'(768);
	localparam logic [GATE_W-1:0]  RST_DIST_GATE  = GATE_W'(26);
	localparam logic [AGATE_W-1:0] RST_ANGLE_GATE = AGATE_W'(819);

	typedef enum logic [IDX_W-1:0] {
		REG_GOAL_X     = 3'd0,
		REG_GOAL_Y     = 3'd1,
		REG_GAIN       = 3'd2,
		REG_MAX_SPEED  = 3'd3,
		REG_DIST_GATE  = 3'd4,
		REG_ANGLE_GATE = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic [GAIN_W-1:0]       gain;
		logic [SPEED_W-1:0]      max_speed;
		logic [GATE_W-1:0]       dist_gate;
		logic [AGATE_W-1:0]      angle_gate;
	} cfg_t;

	typedef struct packed {
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [Z_W-1:0]    z;
		logic signed [HEAD_W-1:0] heading;
	} vec_t;

	typedef struct packed {
		logic [SPEED_W-1:0] linear_speed;
		logic [ANG_W-1:0]   angular_speed;
	} res_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = Z_W'(51472);
			1: r = Z_W'(30386);
			2: r = Z_W'(16055);
			3: r = Z_W'(8150);
			4: r = Z_W'(4091);
			5: r = Z_W'(2047);
			6: r = Z_W'(1024);
			7: r = Z_W'(512);
			default: begin
				if (i <= 16) begin
					r = Z_W'(1) << (16 - i);
				end else begin
					r = '0;
				end
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/go_to_goal_velocity_command_top.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity command
// A pose passes through the front register, the CORDIC stages, the command stages and the output register.
// One pose is taken every cycle while in_ready is high; the CORDIC has one stage per iteration.
// in_ready drops only while the skid entry holds a result behind a stall.
// Reset clears all valid bits and loads the configuration defaults.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_command_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [gtg_pkg::POS_W-1:0]  pos_x,
	input  logic signed [gtg_pkg::POS_W-1:0]  pos_y,
	input  logic signed [gtg_pkg::HEAD_W-1:0] heading,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gtg_pkg::SPEED_W-1:0]       linear_speed,
	output logic [gtg_pkg::ANG_W-1:0]         angular_speed,
	input  logic                              wr_en,
	input  logic [gtg_pkg::IDX_W-1:0]         wr_index,
	input  logic [gtg_pkg::CFG_W-1:0]         wr_data
);

	gtg_pkg::cfg_t cfg_q;
	logic          adv;
	logic          v_s0, v_cordic, v_post;
	gtg_pkg::vec_t vec_s0, vec_cordic;
	gtg_pkg::res_t res_post, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x     <= gtg_pkg::RST_GOAL_X;
			cfg_q.goal_y     <= gtg_pkg::RST_GOAL_Y;
			cfg_q.gain       <= gtg_pkg::RST_GAIN;
			cfg_q.max_speed  <= gtg_pkg::RST_MAX_SPEED;
			cfg_q.dist_gate  <= gtg_pkg::RST_DIST_GATE;
			cfg_q.angle_gate <= gtg_pkg::RST_ANGLE_GATE;
		end else if (wr_en) begin
			unique case (wr_index)
				gtg_pkg::REG_GOAL_X:     cfg_q.goal_x     <= gtg_pkg::POS_W'(wr_data);
				gtg_pkg::REG_GOAL_Y:     cfg_q.goal_y     <= gtg_pkg::POS_W'(wr_data);
				gtg_pkg::REG_GAIN:       cfg_q.gain       <= gtg_pkg::GAIN_W'(wr_data);
				gtg_pkg::REG_MAX_SPEED:  cfg_q.max_speed  <= wr_data;
				gtg_pkg::REG_DIST_GATE:  cfg_q.dist_gate  <= wr_data;
				gtg_pkg::REG_ANGLE_GATE: cfg_q.angle_gate <= gtg_pkg::AGATE_W'(wr_data);
				default: begin
				end
			endcase
		end
	end

	gtg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.heading  (heading),
		.cfg      (cfg_q),
		.v_s0     (v_s0),
		.vec_s0   (vec_s0)
	);

	gtg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_s0),
		.vec_in  (vec_s0),
		.v_out   (v_cordic),
		.vec_out (vec_cordic)
	);

	gtg_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_cordic),
		.vec_in  (vec_cordic),
		.cfg     (cfg_q),
		.v_out   (v_post),
		.res_out (res_post)
	);

	gtg_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_post),
		.res_in    (res_post),
		.out_ready (out_ready),
		.adv       (adv),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign in_ready      = adv;
	assign linear_speed  = res_out.linear_speed;
	assign angular_speed = res_out.angular_speed;

	// A held-back result implies that the output register is occupied.
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("skid entry full while output register empty");

	// The skid entry only fills or stays full behind a stalled output.
	a_skid_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("skid entry full without a stalled output");

	// Driving and turning never happen together.
	a_drive_or_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (linear_speed == '0 || angular_speed == '0))
		else $error("linear and angular speed both non-zero");

endmodule

FILE: rtl/core/gtg_front.sv
// ----------------------------------------------------------------------------
// Go-to-goal front end
// Forms the offset to the target, scales it and folds it into the right half.
// ----------------------------------------------------------------------------
module gtg_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [gtg_pkg::POS_W-1:0]  pos_x,
	input  logic signed [gtg_pkg::POS_W-1:0]  pos_y,
	input  logic signed [gtg_pkg::HEAD_W-1:0] heading,
	input  gtg_pkg::cfg_t                     cfg,
	output logic                              v_s0,
	output gtg_pkg::vec_t                     vec_s0
);

	logic signed [gtg_pkg::DIFF_W-1:0] dx;
	logic signed [gtg_pkg::DIFF_W-1:0] dy;
	logic signed [gtg_pkg::VEC_W-1:0]  x0;
	logic signed [gtg_pkg::VEC_W-1:0]  y0;
	gtg_pkg::vec_t                     vec_d;

	assign dx = gtg_pkg::DIFF_W'(cfg.goal_x) - gtg_pkg::DIFF_W'(pos_x);
	assign dy = gtg_pkg::DIFF_W'(cfg.goal_y) - gtg_pkg::DIFF_W'(pos_y);
	assign x0 = gtg_pkg::VEC_W'(dx) <<< gtg_pkg::PRE_SHIFT;
	assign y0 = gtg_pkg::VEC_W'(dy) <<< gtg_pkg::PRE_SHIFT;

	always_comb begin
		vec_d.heading = heading;
		if (dx[gtg_pkg::DIFF_W-1]) begin
			vec_d.x = -x0;
			vec_d.y = -y0;
			vec_d.z = dy[gtg_pkg::DIFF_W-1] ? -gtg_pkg::PI_Q16 : gtg_pkg::PI_Q16;
		end else begin
			vec_d.x = x0;
			vec_d.y = y0;
			vec_d.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s0 <= vec_d;
		end
	end

endmodule

FILE: rtl/core/gtg_cordic.sv
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC
// Vectoring CORDIC with one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module gtg_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          v_in,
	input  gtg_pkg::vec_t vec_in,
	output logic          v_out,
	output gtg_pkg::vec_t vec_out
);

	logic          pipe_v_s   [gtg_pkg::CORDIC_STAGES+1];
	gtg_pkg::vec_t pipe_vec_s [gtg_pkg::CORDIC_STAGES+1];

	assign pipe_v_s[0]   = v_in;
	assign pipe_vec_s[0] = vec_in;

	for (genvar i = 0; i < gtg_pkg::CORDIC_STAGES; i++) begin : g_stage
		logic signed [gtg_pkg::VEC_W-1:0] xs;
		logic signed [gtg_pkg::VEC_W-1:0] ys;
		gtg_pkg::vec_t                    nxt;

		assign xs = pipe_vec_s[i].x >>> i;
		assign ys = pipe_vec_s[i].y >>> i;

		always_comb begin
			nxt.heading = pipe_vec_s[i].heading;
			if (!pipe_vec_s[i].y[gtg_pkg::VEC_W-1]) begin
				nxt.x = pipe_vec_s[i].x + ys;
				nxt.y = pipe_vec_s[i].y - xs;
				nxt.z = pipe_vec_s[i].z + gtg_pkg::atan_entry(i);
			end else begin
				nxt.x = pipe_vec_s[i].x - ys;
				nxt.y = pipe_vec_s[i].y + xs;
				nxt.z = pipe_vec_s[i].z - gtg_pkg::atan_entry(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_v_s[i+1] <= 1'b0;
			end else if (adv) begin
				pipe_v_s[i+1] <= pipe_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_vec_s[i+1] <= nxt;
			end
		end
	end

	assign v_out   = pipe_v_s[gtg_pkg::CORDIC_STAGES];
	assign vec_out = pipe_vec_s[gtg_pkg::CORDIC_STAGES];

endmodule

FILE: rtl/core/gtg_post.sv
// ----------------------------------------------------------------------------
// Go-to-goal command stage
// Scales the CORDIC magnitude to a distance, applies the gates, the gain and the speed limit.
// ----------------------------------------------------------------------------
module gtg_post (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          v_in,
	input  gtg_pkg::vec_t vec_in,
	input  gtg_pkg::cfg_t cfg,
	output logic          v_out,
	output gtg_pkg::res_t res_out
);

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic [gtg_pkg::PROD_W-1:0]          prod_s1;
	logic signed [gtg_pkg::ANGLE_W-1:0]  angle_s1, angle_s2;
	logic [gtg_pkg::DIST_W-1:0]          dist_s2;
	logic                                turn_s2, turn_s3, near_s3;
	logic [gtg_pkg::LPROD_W-1:0]         lprod_s3;
	logic [gtg_pkg::ANG_W-1:0]           ang_s3;
	gtg_pkg::res_t                       res_s4;

	logic signed [gtg_pkg::Z_W-1:0]      z_rnd;
	logic signed [gtg_pkg::ZR_W-1:0]     z_q12;
	logic signed [gtg_pkg::ANGLE_W-1:0]  angle_d;
	logic [gtg_pkg::PROD_W-1:0]          prod_rnd;
	logic [gtg_pkg::DIST_W-1:0]          dist_d;
	logic signed [gtg_pkg::ANGLE_W-1:0]  gate_ext;
	logic [gtg_pkg::LIN_W-1:0]           lin;
	gtg_pkg::res_t                       res_d;

	assign z_rnd   = vec_in.z + gtg_pkg::ANGLE_RND;
	assign z_q12   = gtg_pkg::ZR_W'(z_rnd >>> 4);
	assign angle_d = gtg_pkg::ANGLE_W'(z_q12) - gtg_pkg::ANGLE_W'(vec_in.heading);

	assign prod_rnd = prod_s1 + gtg_pkg::DIST_RND;
	assign dist_d   = gtg_pkg::DIST_W'(prod_rnd >> gtg_pkg::DIST_SHIFT);
	assign gate_ext = signed'(gtg_pkg::ANGLE_W'(cfg.angle_gate));

	assign lin = gtg_pkg::LIN_W'(lprod_s3 >> gtg_pkg::FRACTION_BITS);

	always_comb begin
		res_d = '0;
		if (!near_s3) begin
			if (turn_s3) begin
				res_d.angular_speed = ang_s3;
			end else if (lin > gtg_pkg::LIN_W'(cfg.max_speed)) begin
				res_d.linear_speed = cfg.max_speed;
			end else begin
				res_d.linear_speed = gtg_pkg::SPEED_W'(lin);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= gtg_pkg::PROD_W'(vec_in.x[gtg_pkg::VEC_W-2:0])
				* gtg_pkg::PROD_W'(gtg_pkg::INV_GAIN);
			angle_s1 <= angle_d;
			dist_s2  <= dist_d;
			angle_s2 <= angle_s1;
			turn_s2  <= angle_s1 > gate_ext;
			near_s3  <= gtg_pkg::CMP_W'(dist_s2) <= gtg_pkg::CMP_W'(cfg.dist_gate);
			lprod_s3 <= gtg_pkg::LPROD_W'(cfg.gain) * gtg_pkg::LPROD_W'(dist_s2);
			turn_s3  <= turn_s2;
			ang_s3   <= gtg_pkg::ANG_W'(angle_s2);
			res_s4   <= res_d;
		end
	end

	assign v_out   = v_s4;
	assign res_out = res_s4;

endmodule

FILE: rtl/core/gtg_skid.sv
// ----------------------------------------------------------------------------
// Go-to-goal output buffer
// Output register with one skid entry; the pipeline advances while it is free.
// ----------------------------------------------------------------------------
module gtg_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  gtg_pkg::res_t res_in,
	input  logic          out_ready,
	output logic          adv,
	output logic          out_valid,
	output gtg_pkg::res_t res_out
);

	logic          out_v_q;
	logic          sk_v_q;
	gtg_pkg::res_t out_res_q;
	gtg_pkg::res_t sk_res_q;
	logic          out_free;

	assign adv      = !sk_v_q;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (out_free) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end
		end else if (out_free) begin
			out_v_q <= v_in;
		end else if (v_in) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (out_free) begin
				out_res_q <= sk_res_q;
			end
		end else if (out_free) begin
			out_res_q <= res_in;
		end else begin
			sk_res_q <= res_in;
		end
	end

	assign out_valid = out_v_q;
	assign res_out   = out_res_q;

endmodule
